FILE: rtl/ustar_block_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// ustar block stream parser assertion macros
// concurrent checks on clk, with and without the reset disable
// ----------------------------------------------------------------------------
`ifndef USTAR_BLOCK_STREAM_PARSER_DEFINES_SVH
`define USTAR_BLOCK_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// check that is off while rst is high
`define USTAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds through reset
`define USTAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define USTAR_ASSERT(label, prop, msg)
`define USTAR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/ustar_pkg.sv
// ----------------------------------------------------------------------------
// ustar package
// types, header layout offsets and codes for the tar stream parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ustar_pkg;

  localparam int SizeBitsDefault = 36;

  // fixed field widths
  localparam int OffBits       = 9;
  localparam int SumBits       = 18;
  localparam int StoredSumBits = 24;
  localparam int ModeBits      = 12;
  localparam int TimeBits      = 36;
  localparam int OutSizeBits   = 36;
  localparam int MaxSizeBits   = 64;

  localparam logic [SumBits-1:0] BlankSum = SumBits'(256);

  // header layout
  localparam logic [OffBits-1:0] NameAt     = 9'd0;
  localparam logic [OffBits-1:0] ModeFirst  = 9'd100;
  localparam logic [OffBits-1:0] ModeLast   = 9'd107;
  localparam logic [OffBits-1:0] SizeFirst  = 9'd124;
  localparam logic [OffBits-1:0] SizeLast   = 9'd135;
  localparam logic [OffBits-1:0] TimeFirst  = 9'd136;
  localparam logic [OffBits-1:0] TimeLast   = 9'd147;
  localparam logic [OffBits-1:0] SumFirst   = 9'd148;
  localparam logic [OffBits-1:0] SumLast    = 9'd155;
  localparam logic [OffBits-1:0] TypeAt     = 9'd156;
  localparam logic [OffBits-1:0] MagicFirst = 9'd257;
  localparam logic [OffBits-1:0] MagicLast  = 9'd261;
  localparam logic [OffBits-1:0] BlockLast  = 9'd511;

  localparam logic [7:0] MagicText [5] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};

  // characters
  localparam logic [7:0] ChBlank   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChSeven   = 8'h37;
  localparam logic [7:0] ChRegular = 8'h30;

  // octal field slots, flags hold skip at 2*f and stop at 2*f+1
  localparam int FldMode  = 0;
  localparam int FldSize  = 1;
  localparam int FldTime  = 2;
  localparam int FldSum   = 3;
  localparam int NumFlds  = 4;
  localparam logic [2*NumFlds-1:0] FieldFlagsReset = 8'h55;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhData   = 2'd1,
    PhSkip   = 2'd2,
    PhDead   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindData   = 2'd1,
    KindError  = 2'd2
  } kind_t;

  typedef struct packed {
    logic magic_ok;
    logic name_ok;
    logic nonzero;
  } check_t;

  localparam check_t CheckReset = '{magic_ok: 1'b1, name_ok: 1'b1, nonzero: 1'b0};

endpackage

FILE: rtl/ustar_if.sv
// ----------------------------------------------------------------------------
// ustar stream interfaces
// valid/ready channels for archive words in and parsed records out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ustar_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;

  modport source (output valid, output archive_byte, input ready);
  modport sink (input valid, input archive_byte, output ready);
endinterface

interface ustar_out_if import ustar_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [7:0]             payload_byte;
  logic [ModeBits-1:0]    file_mode;
  logic [OutSizeBits-1:0] file_size;
  logic [TimeBits-1:0]    mod_time;
  logic [7:0]             type_byte;
  logic                   extracted;
  logic                   last;

  modport source (
    output valid, output kind, output payload_byte, output file_mode,
    output file_size, output mod_time, output type_byte, output extracted,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input file_mode,
    input file_size, input mod_time, input type_byte, input extracted,
    input last, output ready
  );
endinterface

FILE: rtl/ustar_block_stream_parser.sv
// ----------------------------------------------------------------------------
// ustar block stream parser
// byte-serial tar reader: header checks, octal fields, file data passthrough
// ----------------------------------------------------------------------------
// The archive enters one byte per word on the archive channel and is cut into
// 512-byte blocks. A header block is checked (nonzero first name byte, "ustar"
// magic, octal checksum against the byte sum with the checksum field counted
// as blanks) and on its last byte one header record leaves on the result
// channel with mode, size, mtime and the type byte. Regular files (type '0')
// then send every data byte as a word with last marking the final one; data
// of other types and block padding are dropped. An all-zero block after the
// first entry is dropped; before it, it fails as a bad header. A bad header
// gives one error word and the parser then swallows all input until rst.
// Throughput is one archive word per cycle with no gaps while results are
// taken; a word is taken into an input register, then one pass of logic
// updates the parse state and loads the result register. Back pressure on
// the result channel stalls the input register only while the result
// register is full and not being taken. There is no memory and no clearing
// pass after reset.
`timescale 1ns / 1ps
`include "ustar_block_stream_parser_defines.svh"

module ustar_block_stream_parser
  import ustar_pkg::*;
#(
  parameter int SIZE_BITS = SizeBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  ustar_in_if.sink           archive,
  ustar_out_if.source        result
);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------

  // input stage
  logic       in_full;
  logic [7:0] in_byte;

  // parse state
  phase_t                   phase, phase_next;
  logic [OffBits-1:0]       block_offset, block_offset_next;
  logic                     seen_entry, seen_entry_next;
  logic [SIZE_BITS-1:0]     bytes_left, bytes_left_next;
  logic [SumBits-1:0]       sum_acc, sum_acc_next;
  logic [StoredSumBits-1:0] stored_sum, stored_sum_next;
  logic [ModeBits-1:0]      mode_acc, mode_acc_next;
  logic [SIZE_BITS-1:0]     size_acc, size_acc_next;
  logic [TimeBits-1:0]      time_acc, time_acc_next;
  logic [2*NumFlds-1:0]     field_flags, field_flags_next;
  check_t                   check_flags, check_flags_next;
  logic [7:0]               type_hold, type_hold_next;

  // result stage
  logic                   out_full;
  kind_t                  out_kind, out_kind_next;
  logic [7:0]             out_payload, out_payload_next;
  logic [ModeBits-1:0]    out_mode, out_mode_next;
  logic [OutSizeBits-1:0] out_size, out_size_next;
  logic [TimeBits-1:0]    out_time, out_time_next;
  logic [7:0]             out_type, out_type_next;
  logic                   out_extracted, out_extracted_next;
  logic                   out_last, out_last_next;
  logic                   emit;

  // --------------------------------------------------------------------------
  // handshake: the update pass runs when an input word is held and the result register can load
  // --------------------------------------------------------------------------
  logic advance;

  assign advance       = in_full && (!out_full || result.ready);
  assign archive.ready = !in_full || advance;

  // --------------------------------------------------------------------------
  // byte decode
  // --------------------------------------------------------------------------
  logic [7:0]           b;
  logic [OffBits-1:0]   off;
  logic                 end_blk;
  logic                 is_digit;
  logic                 blank_zero;
  logic [NumFlds-1:0]   fld_act;
  logic [NumFlds-1:0]   take;
  logic [2*NumFlds-1:0] flags_upd;
  logic                 in_magic;
  logic [2:0]           magic_idx;
  logic [SumBits-1:0]   sum_add;
  logic [SumBits-1:0]   sum_eff;
  check_t               check_eff;
  logic [7:0]           type_eff;
  logic                 hdr_valid;
  logic                 zero_drop;
  logic                 regular;
  logic                 size_zero;
  logic                 left_zero;
  logic                 left_one;
  logic [MaxSizeBits-1:0] size_ext;

  assign b          = in_byte;
  assign off        = block_offset;
  assign end_blk    = (off == BlockLast);
  assign is_digit   = (b >= ChZero) && (b <= ChSeven);
  assign blank_zero = (b == ChBlank) || (b == ChZero);

  // the four octal fields occupy disjoint byte ranges
  assign fld_act[FldMode] = (off >= ModeFirst) && (off <= ModeLast);
  assign fld_act[FldSize] = (off >= SizeFirst) && (off <= SizeLast);
  assign fld_act[FldTime] = (off >= TimeFirst) && (off <= TimeLast);
  assign fld_act[FldSum]  = (off >= SumFirst) && (off <= SumLast);

  // octal scan: skip leading blanks and zeros, stop at the first non-digit
  always_comb begin
    flags_upd = field_flags;
    take      = '0;
    for (int f = 0; f < NumFlds; f++) begin
      if (fld_act[f] && !field_flags[2*f+1] && !(field_flags[2*f] && blank_zero)) begin
        flags_upd[2*f] = 1'b0;
        if (is_digit) begin
          take[f] = 1'b1;
        end else begin
          flags_upd[2*f+1] = 1'b1;
        end
      end
    end
  end

  assign in_magic  = (off >= MagicFirst) && (off <= MagicLast);
  assign magic_idx = 3'(off - MagicFirst);

  // checksum field bytes count as blanks, which the reset value already holds
  assign sum_add = sum_acc + SumBits'(b);
  assign sum_eff = fld_act[FldSum] ? sum_acc : sum_add;

  always_comb begin
    check_eff = check_flags;
    if (b != 8'd0) begin
      check_eff.nonzero = 1'b1;
    end
    if ((off == NameAt) && (b == 8'd0)) begin
      check_eff.name_ok = 1'b0;
    end
    if (in_magic && (b != MagicText[magic_idx])) begin
      check_eff.magic_ok = 1'b0;
    end
  end

  assign type_eff  = (off == TypeAt) ? b : type_hold;
  assign hdr_valid = check_eff.name_ok && check_eff.magic_ok &&
                     (stored_sum == StoredSumBits'(sum_eff));
  assign zero_drop = !check_eff.nonzero && seen_entry;
  assign regular   = (type_hold == ChRegular);
  assign size_zero = (size_acc == '0);
  assign left_zero = (bytes_left == '0);
  assign left_one  = (bytes_left == SIZE_BITS'(1));

  // size goes out as its low 36 bits, zero filled when narrower
  always_comb begin
    size_ext                  = '0;
    size_ext[SIZE_BITS-1:0]   = size_acc;
  end

  // --------------------------------------------------------------------------
  // phase next state
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next = phase;
    case (phase)
      PhHeader: begin
        if (end_blk && !zero_drop) begin
          if (!hdr_valid) begin
            phase_next = PhDead;
          end else if (size_zero) begin
            // nothing follows, next block is a header again
            phase_next = PhHeader;
          end else if (regular) begin
            phase_next = PhData;
          end else begin
            phase_next = PhSkip;
          end
        end
      end
      PhData, PhSkip: begin
        // back to headers at the block boundary once the data is used up
        if (end_blk && (left_zero || left_one)) begin
          phase_next = PhHeader;
        end
      end
      PhDead: begin
        phase_next = PhDead;
      end
      default: begin
        phase_next = PhHeader;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and result next values
  // --------------------------------------------------------------------------
  always_comb begin
    block_offset_next = block_offset;
    seen_entry_next   = seen_entry;
    bytes_left_next   = bytes_left;
    sum_acc_next      = sum_acc;
    stored_sum_next   = stored_sum;
    mode_acc_next     = mode_acc;
    size_acc_next     = size_acc;
    time_acc_next     = time_acc;
    field_flags_next  = field_flags;
    check_flags_next  = check_flags;
    type_hold_next    = type_hold;

    emit               = 1'b0;
    out_kind_next      = KindHeader;
    out_payload_next   = '0;
    out_mode_next      = '0;
    out_size_next      = '0;
    out_time_next      = '0;
    out_type_next      = '0;
    out_extracted_next = 1'b0;
    out_last_next      = 1'b0;

    case (phase)
      PhHeader: begin
        block_offset_next = off + OffBits'(1);
        sum_acc_next      = sum_eff;
        check_flags_next  = check_eff;
        type_hold_next    = type_eff;
        field_flags_next  = flags_upd;
        // digits are 0x30..0x37, so the low three bits are the value
        if (take[FldMode]) begin
          mode_acc_next = {mode_acc[ModeBits-4:0], b[2:0]};
        end
        if (take[FldSize]) begin
          size_acc_next = {size_acc[SIZE_BITS-4:0], b[2:0]};
        end
        if (take[FldTime]) begin
          time_acc_next = {time_acc[TimeBits-4:0], b[2:0]};
        end
        if (take[FldSum]) begin
          stored_sum_next = {stored_sum[StoredSumBits-4:0], b[2:0]};
        end

        if (end_blk) begin
          if (!zero_drop) begin
            emit = 1'b1;
            if (!hdr_valid) begin
              out_kind_next = KindError;
            end else begin
              out_kind_next      = KindHeader;
              out_mode_next      = mode_acc;
              out_size_next      = size_ext[OutSizeBits-1:0];
              out_time_next      = time_acc;
              out_type_next      = type_hold;
              out_extracted_next = regular;
              out_last_next      = !regular || size_zero;
              seen_entry_next    = 1'b1;
              bytes_left_next    = size_acc;
            end
          end
          // fresh accumulators for the next header
          sum_acc_next     = BlankSum;
          stored_sum_next  = '0;
          mode_acc_next    = '0;
          size_acc_next    = '0;
          time_acc_next    = '0;
          field_flags_next = FieldFlagsReset;
          check_flags_next = CheckReset;
          type_hold_next   = '0;
        end
      end
      PhData, PhSkip: begin
        block_offset_next = off + OffBits'(1);
        if (!left_zero) begin
          bytes_left_next = bytes_left - SIZE_BITS'(1);
          if (phase == PhData) begin
            emit             = 1'b1;
            out_kind_next    = KindData;
            out_payload_next = b;
            out_last_next    = left_one;
          end
        end
      end
      PhDead: begin
        // all input swallowed until reset
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // sequential
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (archive.valid && archive.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (archive.valid && archive.ready) begin
      in_byte <= archive.archive_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhHeader;
      block_offset <= '0;
      seen_entry   <= 1'b0;
      bytes_left   <= '0;
      sum_acc      <= BlankSum;
      stored_sum   <= '0;
      mode_acc     <= '0;
      size_acc     <= '0;
      time_acc     <= '0;
      field_flags  <= FieldFlagsReset;
      check_flags  <= CheckReset;
      type_hold    <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      block_offset <= block_offset_next;
      seen_entry   <= seen_entry_next;
      bytes_left   <= bytes_left_next;
      sum_acc      <= sum_acc_next;
      stored_sum   <= stored_sum_next;
      mode_acc     <= mode_acc_next;
      size_acc     <= size_acc_next;
      time_acc     <= time_acc_next;
      field_flags  <= field_flags_next;
      check_flags  <= check_flags_next;
      type_hold    <= type_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= emit;
    end else if (result.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind      <= out_kind_next;
      out_payload   <= out_payload_next;
      out_mode      <= out_mode_next;
      out_size      <= out_size_next;
      out_time      <= out_time_next;
      out_type      <= out_type_next;
      out_extracted <= out_extracted_next;
      out_last      <= out_last_next;
    end
  end

  assign result.valid        = out_full;
  assign result.kind         = out_kind;
  assign result.payload_byte = out_payload;
  assign result.file_mode    = out_mode;
  assign result.file_size    = out_size;
  assign result.mod_time     = out_time;
  assign result.type_byte    = out_type;
  assign result.extracted    = out_extracted;
  assign result.last         = out_last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // a bad header locks the parser until reset
  `USTAR_ASSERT(a_dead_sticks, (phase == PhDead) |=> (phase == PhDead), "dead phase left")

  // entering the locked phase always comes with an error word on the output
  `USTAR_ASSERT(a_dead_reports, ((phase == PhDead) && ($past(phase) != PhDead)) |-> (out_full && (out_kind == KindError)), "dead without error word")

  // returning to header parsing happens only on a block boundary
  `USTAR_ASSERT(a_header_aligned, ((phase == PhHeader) && ($past(phase) != PhHeader)) |-> (block_offset == '0), "header phase off block boundary")

  // no result is offered in the cycle after reset
  `USTAR_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !result.valid, "result valid after reset")

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// ustar block stream parser testbench
// builds a short tar archive byte by byte (a regular file entry with random
// field encodings, then one closing fault or oversize entry) and checks every
// record word against an in-bench prediction of the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ustar_pkg::*;

  // directory typeflag used by the stimulus
  localparam logic [7:0] TypeDir      = 8'h35;

  // cycles with no word moving on either channel before the run is called hung
  localparam int StallLimit = 3000;
  // long receiver hold-off that backs the parser up
  localparam int HoldCycles = 300;

  typedef enum int {
    FaultNone,
    FaultName,
    FaultMagic,
    FaultSum
  } header_fault_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             payload_byte;
    logic [ModeBits-1:0]    file_mode;
    logic [OutSizeBits-1:0] file_size;
    logic [TimeBits-1:0]    mod_time;
    logic [7:0]             type_byte;
    logic                   extracted;
    logic                   last;
  } tar_record_t;

  // --------------------------------------------------------------------------
  // archive tracker: mirrors the parse state per accepted archive word and
  // keeps the records the parser owes, oldest first
  // --------------------------------------------------------------------------
  class archive_tracker;
    logic [OffBits-1:0]         blk_pos;
    phase_t                     ph;
    bit                         entry_seen;
    logic [SizeBitsDefault-1:0] remaining;
    logic [SumBits-1:0]         byte_sum;
    logic [StoredSumBits-1:0]   sum_field;
    logic [ModeBits-1:0]        mode_val;
    logic [SizeBitsDefault-1:0] size_val;
    logic [TimeBits-1:0]        time_val;
    logic [2*NumFlds-1:0]       fflags;
    check_t                     checks;
    logic [7:0]                 type_val;
    tar_record_t                pending_records [$];
    int                         bad_records;

    function new();
      blk_pos = '0;
      ph = PhHeader;
      entry_seen = 1'b0;
      remaining = '0;
      bad_records = 0;
      clear_header();
    endfunction

    function void clear_header();
      byte_sum = BlankSum;
      sum_field = '0;
      mode_val = '0;
      size_val = '0;
      time_val = '0;
      fflags = FieldFlagsReset;
      checks = CheckReset;
      type_val = '0;
    endfunction

    // one byte of an octal field: skip leading blanks and zeros, stop on non-octal
    function void octal_step(int f, logic [7:0] b);
      logic [2:0] digit;
      digit = b[2:0];
      if (fflags[2*f+1]) return;
      if (fflags[2*f] && (b == ChBlank || b == ChZero)) return;
      fflags[2*f] = 1'b0;
      if (b < ChZero || b > ChSeven) begin
        fflags[2*f+1] = 1'b1;
        return;
      end
      case (f)
        FldMode: mode_val  = (mode_val << 3) + digit;
        FldSize: size_val  = (size_val << 3) + digit;
        FldTime: time_val  = (time_val << 3) + digit;
        default: sum_field = (sum_field << 3) + digit;
      endcase
    endfunction

    function void header_step(logic [OffBits-1:0] off, logic [7:0] b);
      if (b != 8'h00) checks.nonzero = 1'b1;
      if (off == NameAt && b == 8'h00) checks.name_ok = 1'b0;
      if (off >= MagicFirst && off <= MagicLast && b != MagicText[off - MagicFirst])
        checks.magic_ok = 1'b0;
      if (off == TypeAt) type_val = b;
      // the checksum field itself counts as blanks, already in the start value
      if (off < SumFirst || off > SumLast) byte_sum = byte_sum + b;
      if (off >= ModeFirst && off <= ModeLast) octal_step(FldMode, b);
      if (off >= SizeFirst && off <= SizeLast) octal_step(FldSize, b);
      if (off >= TimeFirst && off <= TimeLast) octal_step(FldTime, b);
      if (off >= SumFirst && off <= SumLast) octal_step(FldSum, b);
    endfunction

    function void note_word(logic [7:0] b);
      tar_record_t rec;
      bit          hdr_ok;
      bit          regular;
      if (ph == PhDead) return;
      rec = '0;
      if (ph == PhHeader) begin
        header_step(blk_pos, b);
        if (blk_pos == BlockLast) begin
          hdr_ok = checks.name_ok && checks.magic_ok
                   && (sum_field == StoredSumBits'(byte_sum));
          // an all-zero block after the first entry is dropped without a word
          if (checks.nonzero || !entry_seen) begin
            if (!hdr_ok) begin
              rec.kind = KindError;
              pending_records.push_back(rec);
              ph = PhDead;
            end else begin
              regular = (type_val == ChRegular);
              rec.kind = KindHeader;
              rec.file_mode = mode_val;
              rec.file_size = size_val;
              rec.mod_time = time_val;
              rec.type_byte = type_val;
              rec.extracted = regular;
              rec.last = !regular || size_val == '0;
              pending_records.push_back(rec);
              entry_seen = 1'b1;
              remaining = size_val;
              ph = regular ? PhData : PhSkip;
            end
          end
          clear_header();
        end
      end else if (remaining != '0) begin
        remaining = remaining - 1'b1;
        if (ph == PhData) begin
          rec.kind = KindData;
          rec.payload_byte = b;
          rec.last = (remaining == '0);
          pending_records.push_back(rec);
        end
      end
      blk_pos = blk_pos + 1'b1;
      if ((ph == PhData || ph == PhSkip) && remaining == '0 && blk_pos == '0)
        ph = PhHeader;
    endfunction

    function string record_text(tar_record_t r);
      return $sformatf("kind %0d byte %h mode %o size %0d mtime %0d type %h ext %b last %b",
                       r.kind, r.payload_byte, r.file_mode, r.file_size, r.mod_time,
                       r.type_byte, r.extracted, r.last);
    endfunction

    function void check_record(tar_record_t got);
      tar_record_t want;
      if (pending_records.size() == 0) begin
        bad_records++;
        if (bad_records <= 10) $display("unexpected record: %s", record_text(got));
        return;
      end
      want = pending_records.pop_front();
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte
          || got.file_mode !== want.file_mode || got.file_size !== want.file_size
          || got.mod_time !== want.mod_time || got.type_byte !== want.type_byte
          || got.extracted !== want.extracted || got.last !== want.last) begin
        bad_records++;
        if (bad_records <= 10)
          $display("record mismatch\n  expected %s\n  actual   %s",
                   record_text(want), record_text(got));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ustar_in_if  archive_ch ();
  ustar_out_if result_ch ();

  ustar_block_stream_parser dut (
    .clk    (clk),
    .rst    (rst),
    .archive(archive_ch),
    .result (result_ch)
  );

  archive_tracker tracker = new();

  logic [7:0] hdr_block [512];  // block being assembled before it is sent
  int         words_sent = 0;
  bit         calm = 1'b0;      // closing part of the run: no idling at all
  bit         tx_quiet = 1'b0;  // sender runs without gaps for this entry
  bit         hold_request = 1'b0;
  bit         hold_done = 1'b0;

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offer one archive word, with an occasional idle burst in front of it
  task automatic send_word(input logic [7:0] b);
    int gap;
    if (!calm && !tx_quiet && $urandom_range(0, 15) == 0) begin
      archive_ch.valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    archive_ch.valid <= 1'b1;
    archive_ch.archive_byte <= b;
    @(posedge clk);
    while (!archive_ch.ready) @(posedge clk);
    tracker.note_word(b);
    words_sent++;
  endtask

  task automatic send_block();
    for (int i = 0; i < 512; i++) send_word(hdr_block[i]);
  endtask

  // write an octal number in a random but equivalent encoding: some leading
  // blanks and zeros, the digits, then a terminator and junk after it
  task automatic put_octal(input int start, input int len, input logic [63:0] value);
    logic [7:0]  digs [24];
    logic [63:0] v;
    logic [7:0]  t;
    int          nd;
    int          lead;
    int          pos;
    v = value;
    nd = 0;
    while (v != 64'd0) begin
      digs[nd] = ChZero | {5'd0, v[2:0]};
      v = v >> 3;
      nd++;
    end
    lead = $urandom_range(0, len - nd);
    pos = start;
    repeat (lead) begin
      hdr_block[pos] = $urandom_range(0, 1) ? ChBlank : ChZero;
      pos++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      hdr_block[pos] = digs[i];
      pos++;
    end
    if (pos < start + len) begin
      // a blank only ends the field once a digit has cleared the leading skip
      case ($urandom_range(0, 2))
        0: t = 8'h00;
        1: t = (nd > 0) ? ChBlank : 8'h00;
        default: begin
          t = 8'($urandom);
          if ((t >= ChZero && t <= ChSeven) || t == ChBlank) t = 8'h00;
        end
      endcase
      hdr_block[pos] = t;
      pos++;
      while (pos < start + len) begin
        hdr_block[pos] = 8'($urandom);
        pos++;
      end
    end
  endtask

  // header block with sparse noise outside the checked fields, sealed with
  // its checksum; a fault breaks exactly one of the validity checks
  task automatic build_header(input logic [7:0] tflag, input logic [63:0] size,
                              input logic [63:0] mode, input logic [63:0] mtime,
                              input header_fault_t fault);
    int unsigned sum;
    int          k;
    foreach (hdr_block[i])
      hdr_block[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    hdr_block[NameAt] = 8'($urandom_range(1, 255));
    put_octal(ModeFirst, 8, mode);
    put_octal(SizeFirst, 12, size);
    put_octal(TimeFirst, 12, mtime);
    hdr_block[TypeAt] = tflag;
    for (int i = 0; i < 5; i++) hdr_block[MagicFirst + i] = MagicText[i];
    if (fault == FaultName) hdr_block[NameAt] = 8'h00;
    if (fault == FaultMagic) begin
      k = $urandom_range(0, 4);
      hdr_block[MagicFirst + k] = MagicText[k] ^ 8'($urandom_range(1, 255));
    end
    sum = BlankSum;
    for (int i = 0; i < 512; i++)
      if (i < SumFirst || i > SumLast) sum += hdr_block[i];
    if (fault == FaultSum) sum = sum ^ (1 << $urandom_range(0, 16));
    put_octal(SumFirst, 8, sum);
  endtask

  // full entry: header, size data words, padding to the block edge
  task automatic send_entry(input logic [7:0] tflag, input logic [63:0] size,
                            input logic [63:0] mode, input logic [63:0] mtime);
    tx_quiet = ($urandom_range(0, 3) == 0);
    build_header(tflag, size, mode, mtime, FaultNone);
    send_block();
    // one long receiver hold-off while a big file is streaming
    if (tflag == ChRegular && size >= 200 && !hold_done) begin
      hold_request = 1'b1;
      hold_done = 1'b1;
    end
    repeat (size) send_word(8'($urandom));
    if (size[8:0] != 9'd0) repeat (512 - size[8:0]) send_word(8'($urandom));
  endtask

  function automatic logic [63:0] rand_bits(input int max_width);
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    w = $urandom_range(0, max_width);
    return (w == 0) ? 64'd0 : v & ((64'd1 << w) - 64'd1);
  endfunction

  // mostly short files, some exact block multiples and some crossing a block
  function automatic logic [63:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'd512 * $urandom_range(1, 2);
      2: return $urandom_range(500, 1100);
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  initial begin : archive_side
    int            ending;
    logic [63:0]   huge;
    rst <= 1'b1;
    archive_ch.valid <= 1'b0;
    archive_ch.archive_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // a regular file long enough for the receiver hold-off, idling on both sides
    send_entry(ChRegular, 64'($urandom_range(200, 400)), rand_bits(24), rand_bits(36));

    // closing part without idling: a bad header, or an entry too large to finish
    calm = 1'b1;
    ending = $urandom_range(0, 3);
    if (ending == 3) begin
      huge = $urandom_range(0, 1) ? 64'hfffffffff : (rand_bits(36) | 64'h400);
      build_header($urandom_range(0, 1) ? ChRegular : TypeDir, huge, rand_bits(24),
                   rand_bits(36), FaultNone);
      send_block();
      repeat (100) send_word(8'($urandom));
    end else begin
      build_header(ChRegular, pick_size(), rand_bits(24), rand_bits(36),
                   header_fault_t'(ending + 1));
      send_block();
      // everything after a bad header is swallowed
      repeat (40) send_word(8'($urandom));
    end
    archive_ch.valid <= 1'b0;

    while (tracker.pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.bad_records == 0 && tracker.pending_records.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver side: checks each record word, stalls in bursts, and once holds
  // off for a long stretch so the parser fills and stalls its input
  // --------------------------------------------------------------------------
  initial begin : result_side
    tar_record_t got;
    int          stall_left;
    int          hold_left;
    bit          rx_quiet;
    result_ch.ready <= 1'b0;
    stall_left = 0;
    hold_left = 0;
    rx_quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.kind = kind_t'(result_ch.kind);
        got.payload_byte = result_ch.payload_byte;
        got.file_mode = result_ch.file_mode;
        got.file_size = result_ch.file_size;
        got.mod_time = result_ch.mod_time;
        got.type_byte = result_ch.type_byte;
        got.extracted = result_ch.extracted;
        got.last = result_ch.last;
        tracker.check_record(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (!calm && !rx_quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 9);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no word moving on either channel means a hang
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (rst || (archive_ch.valid && archive_ch.ready)
          || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
